FILE: rtl/core/led_strip_window_remap_unit_macros.svh
// Assertion helpers shared by the remap unit.
`ifndef LED_STRIP_WINDOW_REMAP_UNIT_MACROS_SVH
`define LED_STRIP_WINDOW_REMAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LSWR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lswr_pkg.sv
`timescale 1ns / 1ps

package lswr_pkg;

   // Field widths fixed by the interface.
   localparam int IDX_W      = 6;
   localparam int PROP_W     = 16;
   localparam int COLOR_W    = 32;
   localparam int Q16_W      = 16;
   localparam int SPREAD_W   = 5;
   localparam int LEN_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Datapath widths. Effective spread is at most 31, effective length at most 127.
   localparam int E_W        = 7;
   localparam int R_W        = 7;
   localparam int MA_W       = 26;
   localparam int MB_W       = 8;
   localparam int PROD_W     = MA_W + MB_W;
   localparam int BND_W      = 17;
   localparam int FRAC_SHIFT = 17;
   localparam int NUM_W      = 24;
   localparam int DEN_W      = 18;

   typedef enum logic [0:0] {
      OP_LOAD   = 1'b0,
      OP_RENDER = 1'b1
   } lswr_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_CENTER = 3'd0,
      CSR_WINDOW_WIDTH  = 3'd1,
      CSR_SPREAD_COUNT  = 3'd2,
      CSR_FLIP_EVEN     = 3'd3,
      CSR_FLIP_ODD      = 3'd4,
      CSR_BACKGROUND    = 3'd5,
      CSR_CROP_MODE     = 3'd6,
      CSR_STRIP_LENGTH  = 3'd7
   } lswr_csr_type;

   typedef enum logic [2:0] {
      MUL_CENTER,
      MUL_WIDTH,
      MUL_LOW,
      MUL_HIGH,
      MUL_SPAN
   } lswr_mul_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_C,
      ST_MUL_W,
      ST_MOD_WAIT,
      ST_SUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_BND_HI,
      ST_CHECK,
      ST_ROUTE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_READ,
      ST_EMIT
   } lswr_state_type;

   typedef struct packed {
      lswr_op_type        op;
      logic [PROP_W-1:0]  prop_id;
      logic [IDX_W-1:0]   led_index;
      logic [COLOR_W-1:0] color_in;
   } lswr_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   dest_index;
      logic [COLOR_W-1:0] color_out;
   } lswr_rsp_type;

   typedef struct packed {
      logic         latch_item;
      logic         write_store;
      logic         mul_en;
      lswr_mul_type mul_sel;
      logic         div_start;
      logic         div_resize;
      logic         cap_center;
      logic         cap_rem;
      logic         calc_sum;
      logic         cap_start;
      logic         cap_end;
      logic         check_window;
      logic         take_index;
      logic         take_quot;
      logic         read_store;
      logic         emit;
   } lswr_cmd_type;

   typedef struct packed {
      logic req_render;
      logic req_in_range;
      logic div_busy;
      logic in_window;
      logic crop;
   } lswr_status_type;

endpackage

FILE: rtl/core/lswr_div.sv
`timescale 1ns / 1ps

// Unsigned restoring divider, two quotient bits per cycle.
module lswr_div import lswr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int STEPS = NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [DEN_W:0]   sh1, sh2;
   logic [DEN_W-1:0] r1, r2;
   logic             q1, q2;

   always_comb begin
      sh1 = {rem_ff, quo_ff[NUM_W-1]};
      q1  = sh1 >= {1'b0, dsr_ff};
      r1  = q1 ? DEN_W'(sh1 - {1'b0, dsr_ff}) : sh1[DEN_W-1:0];
      sh2 = {r1, quo_ff[NUM_W-2]};
      q2  = sh2 >= {1'b0, dsr_ff};
      r2  = q2 ? DEN_W'(sh2 - {1'b0, dsr_ff}) : sh2[DEN_W-1:0];

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-3:0], q1, q2};
         rem_in  = r2;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/lswr_dp.sv
`timescale 1ns / 1ps

module lswr_dp import lswr_pkg::*; #(
   parameter int MAX_LEDS   = 64,
   parameter int MAX_SPREAD = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lswr_req_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  lswr_cmd_type          cmd,
   output lswr_status_type       status,
   output logic                  rsp_valid,
   output lswr_rsp_type          rsp_data
);

   localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int WAW = (AW > IDX_W) ? AW : IDX_W;
   localparam int TAW = (AW > R_W) ? AW : R_W;
   localparam int LCW = ($clog2(MAX_LEDS + 1) > LEN_W) ? $clog2(MAX_LEDS + 1) : LEN_W;
   localparam logic [E_W-1:0] SPREAD_LIMIT = E_W'(MAX_SPREAD);
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_SHIFT) - 1);

   // Configuration registers.
   logic [Q16_W-1:0]    center_ff;
   logic [Q16_W-1:0]    width_ff;
   logic [SPREAD_W-1:0] spread_ff;
   logic                flip_even_ff;
   logic                flip_odd_ff;
   logic [COLOR_W-1:0]  bg_ff;
   logic                crop_ff;
   logic [LEN_W-1:0]    len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= Q16_W'(16384);
         width_ff     <= Q16_W'(32768);
         spread_ff    <= SPREAD_W'(1);
         flip_even_ff <= 1'b0;
         flip_odd_ff  <= 1'b0;
         bg_ff        <= '0;
         crop_ff      <= 1'b0;
         len_ff       <= LEN_W'(64);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_CENTER: center_ff    <= csr_wdata[Q16_W-1:0];
            CSR_WINDOW_WIDTH:  width_ff     <= csr_wdata[Q16_W-1:0];
            CSR_SPREAD_COUNT:  spread_ff    <= csr_wdata[SPREAD_W-1:0];
            CSR_FLIP_EVEN:     flip_even_ff <= csr_wdata[0];
            CSR_FLIP_ODD:      flip_odd_ff  <= csr_wdata[0];
            CSR_BACKGROUND:    bg_ff        <= csr_wdata[COLOR_W-1:0];
            CSR_CROP_MODE:     crop_ff      <= csr_wdata[0];
            CSR_STRIP_LENGTH:  len_ff       <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective spread and strip length, clamped to one and to the build limits.
   logic [E_W-1:0] eff_e;
   logic [R_W-1:0] eff_r;
   logic [LCW-1:0] len_ext;

   always_comb begin
      len_ext = LCW'(len_ff);
      if (spread_ff == '0)
         eff_e = E_W'(1);
      else if (E_W'(spread_ff) > SPREAD_LIMIT)
         eff_e = SPREAD_LIMIT;
      else
         eff_e = E_W'(spread_ff);
      if (len_ff == '0)
         eff_r = R_W'(1);
      else if (len_ext > LCW'(MAX_LEDS))
         eff_r = R_W'(MAX_LEDS);
      else
         eff_r = R_W'(len_ff);
   end

   // Item registers.
   logic [PROP_W-1:0] prop_ff;
   logic [IDX_W-1:0]  idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         prop_ff <= req_data.prop_id;
         idx_ff  <= req_data.led_index;
      end
   end

   // Shared multiplier with a registered product.
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [BND_W-1:0]  start_ff, end_ff;
   logic signed [BND_W-1:0]  idx_s, span_val;
   logic signed [MA_W-1:0]   lo_ff, hi_ff;

   always_comb begin
      idx_s    = signed'(BND_W'(idx_ff));
      span_val = idx_s - start_ff;
      case (cmd.mul_sel)
         MUL_CENTER: begin
            mul_a = signed'(MA_W'(center_ff));
            mul_b = signed'(MB_W'(eff_e));
         end
         MUL_WIDTH: begin
            mul_a = signed'(MA_W'(width_ff));
            mul_b = signed'(MB_W'(eff_e));
         end
         MUL_LOW: begin
            mul_a = lo_ff;
            mul_b = signed'(MB_W'(eff_r));
         end
         MUL_HIGH: begin
            mul_a = hi_ff;
            mul_b = signed'(MB_W'(eff_r));
         end
         MUL_SPAN: begin
            mul_a = MA_W'(span_val);
            mul_b = signed'(MB_W'(eff_r));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en)
         prod_ff <= prod_in;
   end

   // Window edges in units of strip length: 2P - S and 2P + S.
   logic [MA_W-1:0]        pc_ff;
   logic [E_W-1:0]         r_ff;
   logic [MA_W-1:0]        r_shift;
   logic signed [MA_W-1:0] p_val, two_p, s_val, lo_in, hi_in;

   always_comb begin
      r_shift = MA_W'({r_ff, {Q16_W{1'b0}}});
      p_val   = signed'(pc_ff) - signed'(r_shift);
      two_p   = p_val <<< 1;
      s_val   = signed'(prod_ff[MA_W-1:0]);
      lo_in   = two_p - s_val;
      hi_in   = two_p + s_val;
   end

   // Division by 2^17 truncating toward zero.
   logic signed [PROD_W-1:0] adj_val, shr_val;
   logic signed [BND_W-1:0]  bnd_val;

   always_comb begin
      adj_val = prod_ff[PROD_W-1] ? prod_ff + TRUNC_BIAS : prod_ff;
      shr_val = adj_val >>> FRAC_SHIFT;
      bnd_val = shr_val[BND_W-1:0];
   end

   // Divider for prop_id mod spread and for the resize index.
   logic [NUM_W-1:0] div_dividend, div_quo;
   logic [DEN_W-1:0] div_divisor, div_rem, den_val;
   logic             div_busy;

   assign den_val      = DEN_W'(end_ff - start_ff);
   assign div_dividend = cmd.div_resize ? prod_ff[NUM_W-1:0] : NUM_W'(prop_ff);
   assign div_divisor  = cmd.div_resize ? den_val : DEN_W'(eff_e);

   lswr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   logic           inside_ff, inside_in;
   logic [R_W-1:0] t_ff, t_max, t_quot;

   always_comb begin
      inside_in = (idx_s >= start_ff) && (idx_s < end_ff);
      t_max     = eff_r - R_W'(1);
      t_quot    = (div_quo > NUM_W'(t_max)) ? t_max : div_quo[R_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_center)   pc_ff     <= prod_ff[MA_W-1:0];
      if (cmd.cap_rem)      r_ff      <= div_rem[E_W-1:0];
      if (cmd.calc_sum) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.cap_start)    start_ff  <= bnd_val;
      if (cmd.cap_end)      end_ff    <= bnd_val;
      if (cmd.check_window) inside_ff <= inside_in;
      if (cmd.take_index)   t_ff      <= R_W'(idx_ff);
      else if (cmd.take_quot) t_ff    <= t_quot;
   end

   // Source line store.
   logic [COLOR_W-1:0] store_mem [MAX_LEDS];
   logic [COLOR_W-1:0] rd_ff;
   logic [WAW-1:0]     waddr_ext;
   logic [TAW-1:0]     raddr_ext;
   logic               load_ok;

   always_comb begin
      waddr_ext = WAW'(req_data.led_index);
      raddr_ext = TAW'(t_ff);
      load_ok   = LCW'(req_data.led_index) < LCW'(MAX_LEDS);
   end

   always_ff @(posedge clock) begin
      if (cmd.write_store && load_ok)
         store_mem[waddr_ext[AW-1:0]] <= req_data.color_in;
      if (cmd.read_store)
         rd_ff <= store_mem[raddr_ext[AW-1:0]];
   end

   // Result register.
   logic               flip;
   logic [R_W-1:0]     dest_full;
   logic               rsp_valid_ff;
   lswr_rsp_type       rsp_ff;

   always_comb begin
      flip      = prop_ff[0] ? flip_odd_ff : flip_even_ff;
      dest_full = flip ? (t_max - R_W'(idx_ff)) : R_W'(idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.dest_index <= dest_full[IDX_W-1:0];
         rsp_ff.color_out  <= inside_ff ? rd_ff : bg_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.req_render   = req_data.op == OP_RENDER;
      status.req_in_range = R_W'(req_data.led_index) < eff_r;
      status.div_busy     = div_busy;
      status.in_window    = inside_ff;
      status.crop         = crop_ff;
   end

endmodule

FILE: rtl/core/lswr_ctrl.sv
`timescale 1ns / 1ps

module lswr_ctrl import lswr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  lswr_status_type status,
   output logic            busy,
   output lswr_cmd_type    cmd
);

   lswr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      busy     = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!status.req_render) begin
                  cmd.write_store = 1'b1;
               end else if (status.req_in_range) begin
                  cmd.latch_item = 1'b1;
                  state_in       = ST_MUL_C;
               end
            end
         end
         ST_MUL_C: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_CENTER;
            cmd.div_start = 1'b1;
            state_in      = ST_MUL_W;
         end
         ST_MUL_W: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_WIDTH;
            cmd.cap_center = 1'b1;
            state_in       = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (!status.div_busy) begin
               cmd.cap_rem = 1'b1;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LOW;
            state_in    = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_HIGH;
            cmd.cap_start = 1'b1;
            state_in      = ST_BND_HI;
         end
         ST_BND_HI: begin
            cmd.cap_end = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check_window = 1'b1;
            state_in         = ST_ROUTE;
         end
         ST_ROUTE: begin
            if (status.crop || !status.in_window) begin
               cmd.take_index = 1'b1;
               state_in       = ST_READ;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_SPAN;
               state_in    = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start  = 1'b1;
            cmd.div_resize = 1'b1;
            state_in       = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            cmd.div_resize = 1'b1;
            if (!status.div_busy) begin
               cmd.take_quot = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_store = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/led_strip_window_remap_unit.sv
`timescale 1ns / 1ps
// Window remap of a source color line onto one prop's LED strip.
// Input transactions are taken on a rising edge with start high and busy low.
// A load transaction writes color_in into the line store at led_index and is done
// in that same edge; busy stays low, so loads may follow every cycle.
// A render transaction asks for LED led_index of prop prop_id and yields one result
// transaction: rsp_valid is high for exactly one cycle with dest_index and color_out.
// After the accepting edge, a render that crops or falls outside the window reads the
// store at its own index; a resized render first divides for the source index. Busy
// is high until the result shows, so one item is in flight at a time. The shared
// divider retires two quotient bits a cycle and runs once for prop_id mod spread and,
// when resizing, once more for the source index.
// A render whose led_index is at or beyond the strip length gives no result.
// The receiver cannot stall: each result stands for one cycle only, and it is
// held in an output register so the next transaction can be accepted meanwhile.
// The csr port writes a register at any edge with csr_we high; write only while idle.
// Synchronous reset restores the register defaults and idles the controller. The
// line store is not cleared and must be loaded before it is read.
`include "led_strip_window_remap_unit_macros.svh"

module led_strip_window_remap_unit import lswr_pkg::*; #(
   parameter int MAX_LEDS   = 64,
   parameter int MAX_SPREAD = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lswr_req_type          req_data,
   output logic                  rsp_valid,
   output lswr_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Command and status between the controller and the datapath.
   lswr_cmd_type    dp_cmd;
   lswr_status_type dp_status;

   lswr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (dp_status),
      .busy   (busy),
      .cmd    (dp_cmd)
   );

   lswr_dp #(
      .MAX_LEDS   (MAX_LEDS),
      .MAX_SPREAD (MAX_SPREAD)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A result strobe is never held over, and it always ends a busy period.
   `LSWR_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `LSWR_ASSERT_IMPL(a_strobe_after_work, clock, reset, rsp_valid, $past(busy), "stray result")
   // A load transaction never produces a result.
   `LSWR_ASSERT_NEXT(a_load_silent, clock, reset, start && !busy && req_data.op == OP_LOAD, !rsp_valid, "load gave a result")
   // The divider has finished whenever a new transaction can be taken.
   `LSWR_ASSERT_IMPL(a_div_idle, clock, reset, start && !busy, !dp_status.div_busy, "divider busy at accept")

endmodule
